>>> design/cip_request_path_rule_matcher_defines.svh
// Assertion macros shared by the request path rule matcher.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef CIP_REQUEST_PATH_RULE_MATCHER_DEFINES_SVH
`define CIP_REQUEST_PATH_RULE_MATCHER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CIP_RPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CIP_RPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cip_rpm_pkg.sv
// Shared types and constants of the request path rule matcher.
// No dependencies; imported by the parser and the top level.
package cip_rpm_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_EARLY   = 2'd2;

  localparam logic [1:0] CFG_RULE_CLASS     = 2'd0;
  localparam logic [1:0] CFG_RULE_ATTRIBUTE = 2'd1;
  localparam logic [1:0] CFG_RULE_TERMS     = 2'd2;
  localparam logic [1:0] CFG_ATTR_EQUAL     = 2'd3;

  localparam logic [1:0] TERMS_CLASS      = 2'd2;
  localparam logic [1:0] TERMS_CLASS_ATTR = 2'd3;

  localparam logic [7:0] SEG_CLASS8  = 8'h20;
  localparam logic [7:0] SEG_CLASS16 = 8'h21;
  localparam logic [7:0] SEG_INST8   = 8'h24;
  localparam logic [7:0] SEG_INST16  = 8'h25;
  localparam logic [7:0] SEG_ATTR8   = 8'h30;

  localparam logic [6:0] SVC_GET_ATTR_LIST = 7'h03;
  localparam logic [6:0] SVC_SET_ATTR_LIST = 7'h04;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic [6:0] service;
    logic [7:0] path_words;
    logic       last_byte;
  } cip_rpm_item_t;

  typedef struct packed {
    logic [15:0] rule_class;
    logic [15:0] rule_attribute;
    logic [1:0]  rule_terms;
    logic        attr_equal_mode;
  } cip_rpm_rule_t;

  typedef struct packed {
    logic       hit;
    logic       matched;
    logic [1:0] status;
  } cip_rpm_verdict_t;

endpackage

>>> design/cip_request_path_rule_matcher.sv
// Channel   | Signals                                   | Direction
// in        | in_valid/in_ready, request byte fields    | input transaction, one byte
// out       | out_valid/out_ready, matched, status      | one verdict per message
// cfg       | cfg_we, cfg_index, cfg_wdata              | rule register write
//
// One byte is taken per cycle while the input is not stalled; a byte passes an input
// register and then the parser, whose verdict lands in the output register.
// Only a full output register that is not taken stalls the input.
// Synchronous active-low reset clears the parse state and loads the rule defaults.
// Depends on cip_rpm_pkg, cip_rpm_parser and cip_request_path_rule_matcher_defines.svh.
`include "cip_request_path_rule_matcher_defines.svh"

module cip_request_path_rule_matcher import cip_rpm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic [6:0]  in_service,
  input  logic [7:0]  in_path_words,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_matched,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cip_rpm_rule_t    rule_r;
  cip_rpm_item_t    item_r;
  logic             item_vld_r;
  logic             out_vld_r;
  logic             out_matched_r;
  logic [1:0]       out_status_r;
  logic             advance;
  cip_rpm_verdict_t verdict;

  assign advance  = item_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r.rule_class      <= '0;
      rule_r.rule_attribute  <= '0;
      rule_r.rule_terms      <= TERMS_CLASS;
      rule_r.attr_equal_mode <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RULE_CLASS:     rule_r.rule_class      <= cfg_wdata;
        CFG_RULE_ATTRIBUTE: rule_r.rule_attribute  <= cfg_wdata;
        CFG_RULE_TERMS:     rule_r.rule_terms      <= cfg_wdata[1:0];
        CFG_ATTR_EQUAL:     rule_r.attr_equal_mode <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.data_byte  <= in_data_byte;
      item_r.first_byte <= in_first_byte;
      item_r.service    <= in_service;
      item_r.path_words <= in_path_words;
      item_r.last_byte  <= in_last_byte;
    end
  end

  cip_rpm_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .item    (item_r),
    .rule    (rule_r),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (verdict.hit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict.hit) begin
      out_matched_r <= verdict.matched;
      out_status_r  <= verdict.status;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_matched = out_matched_r;
  assign out_status  = out_status_r;

  `CIP_RPM_ASSERT_NOW(a_match_only_ok, out_vld_r && out_matched_r, out_status_r == ST_OK, "match reported with non-normal status")
  `CIP_RPM_ASSERT_NOW(a_status_code, out_vld_r, out_status_r <= ST_EARLY, "reserved status code on output")
  `CIP_RPM_ASSERT_NEXT(a_hold_on_stall, item_vld_r && out_vld_r && !out_ready, item_vld_r, "pending byte dropped while the verdict register was blocked")

endmodule

>>> design/cip_rpm_parser.sv
// Segment parser and rule compare for one request byte per step.
// Depends on cip_rpm_pkg; holds the per-message parse state.
module cip_rpm_parser import cip_rpm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  cip_rpm_item_t    item,
  input  cip_rpm_rule_t    rule,
  output cip_rpm_verdict_t verdict
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_SEG, PH_BODY, PH_COUNT, PH_ATTR, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NONE, KIND_CLASS8, KIND_INST8, KIND_ATTR8, KIND_CLASS16, KIND_INST16
  } kind_t;

  phase_t      phase_r, phase_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  words_left_r, words_left_nxt;
  logic [1:0]  byte_idx_r, byte_idx_nxt;
  logic [7:0]  low_byte_r, low_byte_nxt;
  logic [15:0] last_class_r, last_class_nxt;
  logic        class_found_r, class_found_nxt;
  logic        list_svc_r, list_svc_nxt;
  logic [15:0] list_left_r, list_left_nxt;

  always_comb begin
    logic        live;
    logic        seg_end;
    logic        decided;
    logic [15:0] field_val;
    logic [7:0]  cost;
    logic [7:0]  b;

    phase_nxt       = phase_r;
    kind_nxt        = kind_r;
    words_left_nxt  = words_left_r;
    byte_idx_nxt    = byte_idx_r;
    low_byte_nxt    = low_byte_r;
    last_class_nxt  = last_class_r;
    class_found_nxt = class_found_r;
    list_svc_nxt    = list_svc_r;
    list_left_nxt   = list_left_r;
    verdict         = '0;
    live            = 1'b0;
    seg_end         = 1'b0;
    decided         = 1'b0;
    field_val       = '0;
    cost            = 8'd1;
    b               = item.data_byte;

    if (step) begin
      if (item.first_byte) begin
        list_svc_nxt    = item.service inside {SVC_GET_ATTR_LIST, SVC_SET_ATTR_LIST};
        words_left_nxt  = item.path_words;
        kind_nxt        = KIND_NONE;
        byte_idx_nxt    = '0;
        low_byte_nxt    = '0;
        last_class_nxt  = '0;
        class_found_nxt = 1'b0;
        list_left_nxt   = '0;
        if (item.path_words == '0) begin
          verdict.hit    = 1'b1;
          verdict.status = ST_OK;
          phase_nxt      = PH_DONE;
        end else begin
          phase_nxt = PH_SEG;
          live      = 1'b1;
        end
      end else begin
        live = (phase_r != PH_IDLE) && (phase_r != PH_DONE);
      end

      if (live) begin
        case (phase_nxt)
          PH_SEG: begin
            byte_idx_nxt = '0;
            low_byte_nxt = '0;
            phase_nxt    = PH_BODY;
            case (b)
              SEG_CLASS8:  kind_nxt = KIND_CLASS8;
              SEG_INST8:   kind_nxt = KIND_INST8;
              SEG_ATTR8:   kind_nxt = KIND_ATTR8;
              SEG_CLASS16: kind_nxt = KIND_CLASS16;
              SEG_INST16:  kind_nxt = KIND_INST16;
              default: begin
                verdict.hit    = 1'b1;
                verdict.status = ST_UNKNOWN;
                phase_nxt      = PH_DONE;
              end
            endcase
          end
          PH_BODY: begin
            if (kind_nxt == KIND_CLASS8 || kind_nxt == KIND_INST8 ||
                kind_nxt == KIND_ATTR8) begin
              field_val = {8'h00, b};
              seg_end   = 1'b1;
            end else if (byte_idx_nxt == 2'd0) begin
              byte_idx_nxt = 2'd1;
            end else if (byte_idx_nxt == 2'd1) begin
              low_byte_nxt = b;
              byte_idx_nxt = 2'd2;
            end else begin
              field_val    = {b, low_byte_nxt};
              byte_idx_nxt = 2'd0;
              seg_end      = 1'b1;
            end

            if (seg_end) begin
              if (kind_nxt == KIND_CLASS8 || kind_nxt == KIND_CLASS16) begin
                last_class_nxt = field_val;
                if (rule.rule_class == field_val) begin
                  if (rule.rule_terms == TERMS_CLASS) begin
                    decided = 1'b1;
                  end else begin
                    class_found_nxt = 1'b1;
                  end
                end
              end else if (kind_nxt == KIND_ATTR8) begin
                if (rule.rule_terms == TERMS_CLASS_ATTR &&
                    rule.rule_class == last_class_nxt &&
                    (!rule.attr_equal_mode || rule.rule_attribute == field_val)) begin
                  decided = 1'b1;
                end
              end

              if (decided) begin
                verdict.hit     = 1'b1;
                verdict.matched = 1'b1;
                verdict.status  = ST_OK;
                phase_nxt       = PH_DONE;
              end else begin
                if (kind_nxt == KIND_CLASS16 || kind_nxt == KIND_INST16) begin
                  cost = 8'd2;
                end
                words_left_nxt = (words_left_nxt > cost) ? words_left_nxt - cost : '0;
                if (words_left_nxt != '0) begin
                  phase_nxt = PH_SEG;
                end else if (class_found_nxt && list_svc_nxt) begin
                  phase_nxt    = PH_COUNT;
                  byte_idx_nxt = '0;
                  low_byte_nxt = '0;
                end else begin
                  verdict.hit    = 1'b1;
                  verdict.status = ST_OK;
                  phase_nxt      = PH_DONE;
                end
              end
            end
          end
          PH_COUNT, PH_ATTR: begin
            if (byte_idx_nxt == 2'd0) begin
              low_byte_nxt = b;
              byte_idx_nxt = 2'd1;
            end else begin
              field_val    = {b, low_byte_nxt};
              byte_idx_nxt = 2'd0;
              if (phase_nxt == PH_COUNT) begin
                list_left_nxt = field_val;
                if (field_val == '0) begin
                  verdict.hit    = 1'b1;
                  verdict.status = ST_OK;
                  phase_nxt      = PH_DONE;
                end else begin
                  phase_nxt = PH_ATTR;
                end
              end else if (rule.attr_equal_mode ?
                           (rule.rule_attribute == field_val) :
                           (rule.rule_attribute != field_val)) begin
                verdict.hit     = 1'b1;
                verdict.matched = 1'b1;
                verdict.status  = ST_OK;
                phase_nxt       = PH_DONE;
              end else begin
                list_left_nxt = list_left_nxt - 16'd1;
                if (list_left_nxt == '0) begin
                  verdict.hit    = 1'b1;
                  verdict.status = ST_OK;
                  phase_nxt      = PH_DONE;
                end
              end
            end
          end
          default: begin
          end
        endcase

        if (!verdict.hit && item.last_byte) begin
          verdict.hit     = 1'b1;
          verdict.matched = 1'b0;
          verdict.status  = ST_EARLY;
          phase_nxt       = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      kind_r        <= KIND_NONE;
      words_left_r  <= '0;
      byte_idx_r    <= '0;
      last_class_r  <= '0;
      class_found_r <= 1'b0;
      list_svc_r    <= 1'b0;
      list_left_r   <= '0;
    end else begin
      phase_r       <= phase_nxt;
      kind_r        <= kind_nxt;
      words_left_r  <= words_left_nxt;
      byte_idx_r    <= byte_idx_nxt;
      last_class_r  <= last_class_nxt;
      class_found_r <= class_found_nxt;
      list_svc_r    <= list_svc_nxt;
      list_left_r   <= list_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_byte_r <= low_byte_nxt;
  end

endmodule
